[sv/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property under a synchronous active-high reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property that holds during reset as well.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/isaac_pkg.sv]
package isaac_pkg;

   // Request kinds.
   localparam logic [1:0] KIND_LOAD   = 2'd0;
   localparam logic [1:0] KIND_INIT_S = 2'd1;
   localparam logic [1:0] KIND_INIT_U = 2'd2;
   localparam logic [1:0] KIND_NEXT   = 2'd3;

   localparam logic [31:0] GOLDEN = 32'h9e3779b9;

   typedef logic [31:0] word_type;
   typedef word_type lanes_type [8];

   // One line j of the golden-ratio mix: lane j takes a shifted copy of lane j+1,
   // lane j+3 adds lane j and lane j+1 adds lane j+2, all modulo eight.
   // Eight lines in order make one full round.
   function automatic lanes_type lane_step(lanes_type vi, logic [2:0] j);
      lanes_type v;
      logic [2:0] j1, j2, j3;
      word_type sh;
      v  = vi;
      j1 = j + 3'd1;
      j2 = j + 3'd2;
      j3 = j + 3'd3;
      case (j)
         3'd0:    sh = v[j1] << 11;
         3'd1:    sh = v[j1] >> 2;
         3'd2:    sh = v[j1] << 8;
         3'd3:    sh = v[j1] >> 16;
         3'd4:    sh = v[j1] << 10;
         3'd5:    sh = v[j1] >> 4;
         3'd6:    sh = v[j1] << 8;
         default: sh = v[j1] >> 9;
      endcase
      v[j]  = v[j] ^ sh;
      v[j3] = v[j3] + v[j];
      v[j1] = v[j1] + v[j2];
      return v;
   endfunction

endpackage

[sv/isaac_ram.sv]
module isaac_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/isaac_random_generator_unit.sv]
// ISAAC word generator with a memory of 2^LOG2_SIZE words held in a RAM
// with one read port and one write port, and a seed store in a second RAM.
// A next-word transfer runs the memory traffic (read m[i], take it and read
// m[i+half], take that and read the indirect entry, write y back while
// reading m[y], form the new b), then registers the word. The next request
// is taken once the result has been transferred. The mix runs one line of a
// round per cycle. An init runs the four scrambles, one fill pass (two with
// seed), then a generation block whose words are dropped. A next item
// before any init gives no result.
module isaac_random_generator_unit
   import isaac_pkg::*;
#(
   parameter int LOG2_SIZE = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_seed_index,
   input  logic [31:0] req_seed_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_random_word
);

   localparam int SIZE = 1 << LOG2_SIZE;
   localparam int AW   = LOG2_SIZE;
   localparam logic [AW-1:0] HALF = AW'(SIZE / 2);

   // Sequencer codes.
   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_MIX4  = 5'd1;
   localparam logic [4:0] ST_FRD   = 5'd2;  // issue read of addend k
   localparam logic [4:0] ST_FACC  = 5'd3;  // take addend k
   localparam logic [4:0] ST_FMIX  = 5'd4;
   localparam logic [4:0] ST_FWR   = 5'd5;
   localparam logic [4:0] ST_G0    = 5'd6;  // read m[p]
   localparam logic [4:0] ST_G1    = 5'd7;  // take x, read m[p+half]
   localparam logic [4:0] ST_G2    = 5'd8;  // take m[p+half], read m[x]
   localparam logic [4:0] ST_G3    = 5'd9;  // take m[x], write y, read m[y]
   localparam logic [4:0] ST_G4    = 5'd10; // take m[y], compute b
   localparam logic [4:0] ST_OUT   = 5'd11;

   logic [4:0]     state_ff, state_in;
   logic           ready_ff, ready_in;
   logic           seeded_ff, seeded_in;
   logic           pass2_ff, pass2_in;    // second fill pass of a seeded init
   logic           drop_ff, drop_in;      // generation words are discarded
   logic [4:0]     mixcnt_ff, mixcnt_in;  // round and line of the scrambles
   logic [AW-1:0]  blk_ff, blk_in;        // base of the eight-word group
   logic [2:0]     k_ff, k_in;
   lanes_type      v_ff, v_in;
   word_type       a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic [AW-1:0]  p_ff, p_in;
   word_type       x_ff, x_in, y_ff, y_in, t_ff, t_in;
   logic [AW:0]    gcnt_ff, gcnt_in;
   logic           rsp_valid_ff, rsp_valid_in;
   word_type       rsp_word_ff, rsp_word_in;

   logic           m_we, s_we;
   logic [AW-1:0]  m_waddr, m_raddr, s_waddr, s_raddr;
   word_type       m_wdata, m_rdata, s_wdata, s_rdata;
   logic           rd_seed_ff, rd_seed_in;

   isaac_ram #(.WIDTH(32), .DEPTH(SIZE)) u_mix_ram (
      .clock(clock), .wr_en(m_we), .wr_addr(m_waddr), .wr_data(m_wdata),
      .rd_addr(m_raddr), .rd_data(m_rdata)
   );

   isaac_ram #(.WIDTH(32), .DEPTH(SIZE)) u_seed_ram (
      .clock(clock), .wr_en(s_we), .wr_addr(s_waddr), .wr_data(s_wdata),
      .rd_addr(s_raddr), .rd_data(s_rdata)
   );

   assign req_ready       = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_random_word = rsp_word_ff;

   // Sequencer and datapath.
   always_comb begin
      logic    accept;
      word_type yn, addend;
      lanes_type vm;
      accept       = req_valid && req_ready;
      state_in     = state_ff;
      ready_in     = ready_ff;
      seeded_in    = seeded_ff;
      pass2_in     = pass2_ff;
      drop_in      = drop_ff;
      mixcnt_in    = mixcnt_ff;
      blk_in       = blk_ff;
      k_in         = k_ff;
      v_in         = v_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      p_in         = p_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      t_in         = t_ff;
      gcnt_in      = gcnt_ff;
      rd_seed_in   = rd_seed_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_word_in  = rsp_word_ff;
      m_we         = 1'b0;
      m_waddr      = p_ff;
      m_wdata      = y_ff;
      m_raddr      = p_ff;
      s_we         = 1'b0;
      s_waddr      = p_ff;
      s_wdata      = b_ff;
      s_raddr      = blk_ff | AW'(k_ff);
      yn           = y_ff;
      addend       = rd_seed_ff ? s_rdata : m_rdata;
      vm           = lane_step(v_ff, (state_ff == ST_MIX4) ? mixcnt_ff[2:0] : k_ff);

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_kind)
                  KIND_LOAD: begin
                     s_we    = 1'b1;
                     s_waddr = AW'(req_seed_index);
                     s_wdata = req_seed_word;
                  end
                  KIND_INIT_S, KIND_INIT_U: begin
                     seeded_in = (req_kind == KIND_INIT_S);
                     pass2_in  = 1'b0;
                     a_in      = '0;
                     b_in      = '0;
                     c_in      = '0;
                     mixcnt_in = '0;
                     for (int i = 0; i < 8; i++) v_in[i] = GOLDEN;
                     state_in  = ST_MIX4;
                  end
                  KIND_NEXT: begin
                     if (ready_ff) begin
                        drop_in  = 1'b0;
                        gcnt_in  = '0;
                        state_in = ST_G0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_MIX4: begin
            v_in      = vm;
            mixcnt_in = mixcnt_ff + 5'd1;
            if (mixcnt_ff == 5'd31) begin
               blk_in   = '0;
               k_in     = '0;
               state_in = seeded_ff ? ST_FRD : ST_FMIX;
            end
         end
         ST_FRD: begin
            m_raddr    = blk_ff | AW'(k_ff);
            rd_seed_in = !pass2_ff;
            state_in   = ST_FACC;
         end
         ST_FACC: begin
            v_in[k_ff] = v_ff[k_ff] + addend;
            k_in       = k_ff + 3'd1;
            state_in   = (k_ff == 3'd7) ? ST_FMIX : ST_FRD;
         end
         // One mix line per cycle, k counting the lines.
         ST_FMIX: begin
            v_in = vm;
            k_in = k_ff + 3'd1;
            if (k_ff == 3'd7) begin
               state_in = ST_FWR;
            end
         end
         ST_FWR: begin
            m_we    = 1'b1;
            m_waddr = blk_ff | AW'(k_ff);
            m_wdata = v_ff[k_ff];
            k_in    = k_ff + 3'd1;
            if (k_ff == 3'd7) begin
               blk_in = blk_ff + AW'(8);
               if (blk_ff == AW'(SIZE - 8)) begin
                  if (seeded_ff && !pass2_ff) begin
                     pass2_in = 1'b1;
                     state_in = ST_FRD;
                  end else begin
                     p_in     = '0;
                     gcnt_in  = '0;
                     drop_in  = 1'b1;
                     state_in = ST_G0;
                  end
               end else begin
                  state_in = (seeded_ff) ? ST_FRD : ST_FMIX;
               end
            end
         end
         ST_G0: begin
            m_raddr = p_ff;
            if (p_ff == '0) begin
               c_in = c_ff + 32'd1;
               b_in = b_ff + c_ff + 32'd1;
            end
            case (p_ff[1:0])
               2'd0:    t_in = a_ff << 13;
               2'd1:    t_in = a_ff >> 6;
               2'd2:    t_in = a_ff << 2;
               default: t_in = a_ff >> 16;
            endcase
            state_in = ST_G1;
         end
         ST_G1: begin
            x_in     = m_rdata;
            m_raddr  = p_ff + HALF;
            state_in = ST_G2;
         end
         ST_G2: begin
            a_in     = (a_ff ^ t_ff) + m_rdata;
            m_raddr  = x_ff[AW+1:2];
            state_in = ST_G3;
         end
         ST_G3: begin
            yn       = m_rdata + a_ff + b_ff;
            y_in     = yn;
            m_we     = 1'b1;
            m_waddr  = p_ff;
            m_wdata  = yn;
            m_raddr  = yn[2*AW+1:AW+2];
            state_in = ST_G4;
         end
         ST_G4: begin
            // Read-during-write to the same entry returns the new word via y.
            b_in     = ((y_ff[2*AW+1:AW+2] == p_ff) ? y_ff : m_rdata) + x_ff;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            s_we    = 1'b1;
            s_waddr = p_ff;
            s_wdata = b_ff;
            p_in    = p_ff + AW'(1);
            if (drop_ff) begin
               gcnt_in = gcnt_ff + 1'b1;
               if (gcnt_ff == (AW+1)'(SIZE - 1)) begin
                  p_in     = '0;
                  ready_in = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_G0;
               end
            end else begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = b_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Reset clears state, ready, result valid, a, b, c and p; the rest is not reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         a_ff         <= '0;
         b_ff         <= '0;
         c_ff         <= '0;
         p_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
         a_ff         <= a_in;
         b_ff         <= b_in;
         c_ff         <= c_in;
         p_ff         <= p_in;
      end
      seeded_ff   <= seeded_in;
      pass2_ff    <= pass2_in;
      drop_ff     <= drop_in;
      mixcnt_ff   <= mixcnt_in;
      blk_ff      <= blk_in;
      k_ff        <= k_in;
      v_ff        <= v_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      t_ff        <= t_in;
      gcnt_ff     <= gcnt_in;
      rd_seed_ff  <= rd_seed_in;
      rsp_word_ff <= rsp_word_in;
   end

endmodule

[sv/isaac_checker.sv]
`include "assert_macros.svh"

module isaac_checker
   import isaac_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_kind,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_random_word
);

   logic req_take, rsp_wait;

   assign req_take = req_valid && req_ready;
   assign rsp_wait = rsp_valid && !rsp_ready;

   // A waiting result holds its word.
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_wait |=> rsp_valid && $stable(rsp_random_word), "result changed")
   // No new request is taken while a result still waits.
   `ASSERT_CLK(a_no_accept_busy, clock, reset, rsp_valid |-> !req_ready, "request taken while busy")
   // A load transfer never produces a result in the following cycle.
   `ASSERT_CLK(a_load_silent, clock, reset, req_take && req_kind == KIND_LOAD |=> !rsp_valid, "load gave result")
   // Reset leaves no result pending.
   `ASSERT_ALWAYS(a_reset_clear, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind isaac_random_generator_unit isaac_checker u_isaac_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .req_kind(req_kind), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_random_word(rsp_random_word)
);

[test/tb_top.sv]
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import isaac_pkg::*;

   // Scoreboard: keeps its own copy of the generator state and a queue of
   // predicted words.
   class isaac_scoreboard;
      localparam int NW = 256;
      logic [31:0] mem [NW];
      logic [31:0] seeds [NW];
      logic [31:0] acc_a, acc_b, blocks;
      int unsigned pos;
      bit primed;
      logic [31:0] pending_words [$];
      int unsigned error_count;

      function new();
         foreach (mem[i]) mem[i] = '0;
         foreach (seeds[i]) seeds[i] = '0;
         acc_a = '0;
         acc_b = '0;
         blocks = '0;
         pos = 0;
         primed = 0;
         error_count = 0;
      endfunction

      // Eight-lane golden-ratio scramble.
      function void scramble(ref logic [31:0] v [8]);
         v[0] ^= v[1] << 11; v[3] += v[0]; v[1] += v[2];
         v[1] ^= v[2] >> 2;  v[4] += v[1]; v[2] += v[3];
         v[2] ^= v[3] << 8;  v[5] += v[2]; v[3] += v[4];
         v[3] ^= v[4] >> 16; v[6] += v[3]; v[4] += v[5];
         v[4] ^= v[5] << 10; v[7] += v[4]; v[5] += v[6];
         v[5] ^= v[6] >> 4;  v[0] += v[5]; v[6] += v[7];
         v[6] ^= v[7] << 8;  v[1] += v[6]; v[7] += v[0];
         v[7] ^= v[0] >> 9;  v[2] += v[7]; v[0] += v[1];
      endfunction

      // One generator step; the word also lands in the seed store.
      function logic [31:0] step_word();
         logic [31:0] a, t, x, y;
         int unsigned p;
         p = pos;
         a = acc_a;
         if (p == 0) begin
            blocks += 1;
            acc_b += blocks;
         end
         case (p % 4)
            0: t = a << 13;
            1: t = a >> 6;
            2: t = a << 2;
            default: t = a >> 16;
         endcase
         x = mem[p];
         a = (a ^ t) + mem[(p + NW / 2) % NW];
         y = mem[(x >> 2) % NW] + a + acc_b;
         mem[p] = y;
         acc_b = mem[(y >> 10) % NW] + x;
         seeds[p] = acc_b;
         acc_a = a;
         pos = (p + 1) % NW;
         return acc_b;
      endfunction

      function void fill(ref logic [31:0] v [8], input int src);
         for (int i = 0; i < NW; i += 8) begin
            for (int k = 0; k < 8; k++) begin
               if (src == 1) v[k] += seeds[i + k];
               else if (src == 2) v[k] += mem[i + k];
            end
            scramble(v);
            for (int k = 0; k < 8; k++) mem[i + k] = v[k];
         end
      endfunction

      function void seed_generator(bit seeded);
         logic [31:0] v [8];
         logic [31:0] dropped;
         acc_a = '0;
         acc_b = '0;
         blocks = '0;
         foreach (v[i]) v[i] = isaac_pkg::GOLDEN;
         for (int i = 0; i < 4; i++) scramble(v);
         if (seeded) begin
            fill(v, 1);
            fill(v, 2);
         end else begin
            fill(v, 0);
         end
         pos = 0;
         for (int i = 0; i < NW; i++) dropped = step_word();
         pos = 0;
         primed = 1;
      endfunction

      // Notes an accepted input transfer.
      function void note_request(logic [1:0] kind, logic [7:0] idx, logic [31:0] word);
         case (kind)
            isaac_pkg::KIND_LOAD:   seeds[idx] = word;
            isaac_pkg::KIND_INIT_S: seed_generator(1);
            isaac_pkg::KIND_INIT_U: seed_generator(0);
            default: if (primed) pending_words.push_back(step_word());
         endcase
      endfunction

      task report(string what);
         $display("MISMATCH at %0t: %s", $time, what);
         error_count++;
      endtask

      // Checks an accepted result transfer.
      task check_word(logic [31:0] got);
         logic [31:0] want;
         if (pending_words.size() == 0) begin
            report($sformatf("unexpected word %h", got));
         end else begin
            want = pending_words.pop_front();
            if (got !== want) report($sformatf("random_word %h, expected %h", got, want));
         end
      endtask
   endclass

   localparam int LIMIT = 3000000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [1:0]  req_kind = KIND_LOAD;
   logic [7:0]  req_seed_index = '0;
   logic [31:0] req_seed_word = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [31:0] rsp_random_word;

   isaac_scoreboard board = new();
   int send_idle = 0;
   int recv_stall = 0;
   bit hold_off = 0;
   int unsigned cycles = 0;

   isaac_random_generator_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_kind(req_kind),
      .req_seed_index(req_seed_index), .req_seed_word(req_seed_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_random_word(rsp_random_word)
   );

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // Watchdog on the cycle count.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Receiver: stalls at random, or holds off completely during pressure.
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready && !reset) board.check_word(rsp_random_word);
      rsp_ready <= !hold_off && ($urandom_range(99) >= recv_stall);
   end

   // Offers one item and waits for its transfer. Valid stays high afterwards
   // so that a following item can go back to back; idle cycles and drain()
   // take it low.
   task send(logic [1:0] kind, logic [7:0] idx, logic [31:0] word);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_kind <= kind;
      req_seed_index <= idx;
      req_seed_word <= word;
      do @(posedge clock); while (!req_ready);
      board.note_request(kind, idx, word);
   endtask

   // Waits until every predicted word has come, then lets the block settle.
   task drain();
      req_valid <= 0;
      while (board.pending_words.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task load_random(int count);
      for (int i = 0; i < count; i++) send(KIND_LOAD, 8'($urandom()), $urandom());
   endtask

   task random_phase(int count);
      int r;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(99);
         if (r < 85) send(KIND_NEXT, 8'($urandom()), $urandom());
         else if (r < 95) send(KIND_LOAD, 8'($urandom()), $urandom());
         else if (r < 97) send(KIND_INIT_S, 8'($urandom()), $urandom());
         else send(KIND_INIT_U, 8'($urandom()), $urandom());
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: next before any init, unseeded init, then extremes of the loads.
      // The unseeded init leaves every seed entry written with generated words.
      send(KIND_NEXT, 8'hff, 32'hffff_ffff);
      send(KIND_INIT_U, 8'h00, 32'h0);
      for (int i = 0; i < 6; i++) send(KIND_NEXT, 8'h00, 32'h0);
      for (int i = 0; i < 7; i++)
         send(KIND_LOAD, i[7:0], (i % 2) ? 32'hffff_ffff : 32'h0);
      send(KIND_LOAD, 8'hff, 32'hffff_ffff);
      send(KIND_INIT_S, 8'hff, 32'hffff_ffff);
      for (int i = 0; i < 6; i++) send(KIND_NEXT, 8'hff, 32'hffff_ffff);
      // Seeded init reusing the generated words left in the seed store.
      send(KIND_INIT_S, 8'h00, 32'h0);
      for (int i = 0; i < 4; i++) send(KIND_NEXT, 8'h55, 32'haaaa_5555);
      drain();

      // Fresh random seeds, then the idling phases.
      load_random(16);
      send(KIND_INIT_S, 8'h00, 32'h0);
      random_phase(130);
      send_idle = 72;
      random_phase(130);
      send_idle = 0;
      recv_stall = 72;
      random_phase(130);
      send_idle = 18;
      recv_stall = 18;
      random_phase(130);
      send_idle = 0;
      recv_stall = 0;

      // Long receiver hold-off while the sender keeps offering items.
      fork
         begin
            hold_off = 1;
            repeat (300) @(posedge clock);
            hold_off = 0;
         end
         begin
            for (int i = 0; i < 20; i++) send(KIND_NEXT, 8'($urandom()), $urandom());
            req_valid <= 0;
         end
      join
      drain();
      for (int i = 0; i < 10; i++) send(KIND_NEXT, 8'h0f, 32'h0);
      drain();

      if (board.error_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end
endmodule

[files.f]
+incdir+sv
sv/isaac_pkg.sv
sv/isaac_ram.sv
sv/isaac_random_generator_unit.sv
sv/isaac_checker.sv
test/tb_top.sv
